// ----- hdl/scc_pkg.sv -----
// Shared types, widths and the constant divider for the stick command conditioner.
// No dependencies; used by stick_command_conditioner.

package scc_pkg;

   // Field widths
   localparam int unsigned AdcWidth      = 12;
   localparam int unsigned ThrottleWidth = 11;
   localparam int unsigned HeadingWidth  = 9;
   localparam int unsigned AngleWidth    = 8;

   // Stream widths, padded to whole bytes
   localparam int unsigned ReqDataWidth = 64;
   localparam int unsigned RspDataWidth = 40;

   // Mapping constants
   localparam int unsigned OffsetSpan   = 500;
   localparam int unsigned StickSpan    = 3000;
   localparam int unsigned StickTop     = 2000;
   localparam int unsigned ThrottleMin  = 1000;
   localparam int unsigned ThrottleMax  = 2000;
   localparam int unsigned RateScale    = 20;
   localparam int unsigned RateBias     = 10;
   localparam int unsigned HeadingLimit = 180;
   localparam int unsigned AngleScale   = 180;
   localparam int unsigned AngleBias    = 90;
   localparam int unsigned AngleDead    = 10;
   localparam int unsigned AdcFull      = 4095;

   // One set of stick samples, last field in the lowest bits
   typedef struct packed {
      logic                  arm_request;
      logic                  precision_mode;
      logic [AdcWidth-1:0]   pitch_stick;
      logic [AdcWidth-1:0]   roll_stick;
      logic [AdcWidth-1:0]   yaw_stick;
      logic [AdcWidth-1:0]   throttle_stick;
      logic [AdcWidth-1:0]   pot_sample;
   } req_item_type;

   // One set of flight commands, last field in the lowest bits
   typedef struct packed {
      logic                            motors_armed;
      logic signed [AngleWidth-1:0]    pitch_cmd;
      logic signed [AngleWidth-1:0]    roll_cmd;
      logic signed [HeadingWidth-1:0]  yaw_cmd;
      logic [ThrottleWidth-1:0]        throttle_cmd;
   } rsp_item_type;

   // Divide by 4095 for dividends below 4095 * 4096: take the quotient by 4096,
   // then the remainder stays below twice the divisor and one correction settles it
   function automatic logic [11:0] div_full_scale(input logic [23:0] dividend);
      logic [11:0] quot;
      logic [12:0] rem;
      begin
         quot = dividend[23:12];
         rem  = {1'b0, dividend[11:0]} + {1'b0, quot};
         if (rem >= 13'(AdcFull)) begin
            quot = quot + 12'd1;
         end
         return quot;
      end
   endfunction

endpackage

// ----- hdl/stick_command_conditioner.sv -----
// Stick command conditioner top level: input register, conditioning logic, result register.
// Depends on scc_pkg for item types, constants and the divide-by-full-scale function.
//
// Usage:
//   req_* carries one set of five 12-bit ADC samples plus precision and arm flags per
//   control tick; rsp_* returns one set of flight commands for each item taken.
//   The potentiometer is smoothed by a 3/4 IIR filter (primed by the first item after
//   reset) and added to the mapped throttle stick; yaw is integrated into a heading;
//   roll and pitch get a deadband and optional halving.
//   Each item is captured in the input register on acceptance; its result is loaded into
//   the result register when that one is empty or taken. Throughput is one item per cycle
//   while rsp_tready stays high: the filter and heading registers update in the same cycle
//   as the item leaves the input register, so no stall is needed between dependent items.
//   The critical path is the constant multiply and single-step divide by full scale
//   on the filtered potentiometer value, followed by the throttle add and clamp.
//   When the receiver holds rsp_tready low, the result register holds its item and
//   the input register stalls only if it is also full; req_tready falls then.
//   Synchronous reset empties both registers, clears the filter, its primed flag and
//   the heading accumulator.

module stick_command_conditioner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pot_sample[11:0], throttle_stick[23:12], yaw_stick[35:24], roll_stick[47:36],
   // pitch_stick[59:48], precision_mode[60], arm_request[61], zero[63:62]
   input  logic [scc_pkg::ReqDataWidth-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // throttle_cmd[10:0], yaw_cmd[19:11], roll_cmd[27:20], pitch_cmd[35:28],
   // motors_armed[36], zero[39:37]
   output logic [scc_pkg::RspDataWidth-1:0] rsp_tdata
);

   // Roll or pitch: map to -90..90, apply deadband, halve toward zero in precision mode
   function automatic logic signed [7:0] angle_cmd(input logic [11:0] raw, input logic precise);
      logic [19:0]       prod;
      logic [11:0]       quot;
      logic signed [8:0] ang;
      logic signed [7:0] ang8;
      logic signed [7:0] biased;
      begin
         prod = {8'd0, raw} * 20'(scc_pkg::AngleScale);
         quot = scc_pkg::div_full_scale({4'd0, prod});
         ang  = $signed({1'b0, quot[7:0]}) - 9'sd90;
         if ((ang > -9'sd10) && (ang < 9'sd10)) begin
            ang = 9'sd0;
         end
         ang8   = ang[7:0];
         biased = ang8 + $signed({7'd0, ang8[7]});
         if (precise) begin
            ang8 = biased >>> 1;
         end
         return ang8;
      end
   endfunction

   scc_pkg::req_item_type       req_item;
   scc_pkg::req_item_type       in_item_ff;
   logic                        in_valid_ff;
   logic                        in_valid_in;
   scc_pkg::rsp_item_type       out_item_ff;
   scc_pkg::rsp_item_type       out_item_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        advance;
   logic                        take;

   logic [11:0]                 pot_filter_ff;
   logic [11:0]                 pot_filter_in;
   logic                        primed_ff;
   logic signed [8:0]           yaw_accum_ff;
   logic signed [8:0]           yaw_accum_in;

   logic [11:0]                 filt_base;
   logic [13:0]                 filt_sum;
   logic [20:0]                 offset_prod;
   logic [11:0]                 offset_q;
   logic [23:0]                 stick_prod;
   logic [11:0]                 stick_q;
   logic signed [12:0]          throttle_sum;
   logic [16:0]                 rate_prod;
   logic [4:0]                  rate_q;
   logic signed [5:0]           rate;
   logic signed [9:0]           heading_sum;

   assign req_item = scc_pkg::req_item_type'(req_tdata[61:0]);

   // Handshake: result register moves when empty or taken; input register follows
   assign advance      = !out_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign take         = in_valid_ff && advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // Conditioning logic between the two registers
   always_comb begin
      // Prime on the first item, then IIR update
      filt_base     = primed_ff ? pot_filter_ff : in_item_ff.pot_sample;
      filt_sum      = ({2'd0, filt_base} << 1) + {2'd0, filt_base} +
                      {2'd0, in_item_ff.pot_sample};
      pot_filter_in = filt_sum[13:2];

      // Throttle: filtered offset plus mapped stick, clamped
      offset_prod  = {9'd0, pot_filter_in} * 21'(scc_pkg::OffsetSpan);
      offset_q     = scc_pkg::div_full_scale({3'd0, offset_prod});
      stick_prod   = {12'd0, in_item_ff.throttle_stick} * 24'(scc_pkg::StickSpan);
      stick_q      = scc_pkg::div_full_scale(stick_prod);
      throttle_sum = 13'sd2000 - $signed({1'b0, stick_q}) + $signed({1'b0, offset_q});
      if (throttle_sum < 13'sd1000) begin
         throttle_sum = 13'sd1000;
      end else if (throttle_sum > 13'sd2000) begin
         throttle_sum = 13'sd2000;
      end

      // Yaw rate with deadband, integrated and clamped
      rate_prod = {5'd0, in_item_ff.yaw_stick} * 17'(scc_pkg::RateScale);
      rate_q    = rate_prod[16:12];
      rate      = $signed({1'b0, rate_q}) - 6'sd10;
      if ((rate > -6'sd2) && (rate < 6'sd2)) begin
         rate = 6'sd0;
      end
      heading_sum = {yaw_accum_ff[8], yaw_accum_ff} + 10'(rate);
      if (heading_sum < -10'sd180) begin
         heading_sum = -10'sd180;
      end else if (heading_sum > 10'sd180) begin
         heading_sum = 10'sd180;
      end
      yaw_accum_in = heading_sum[8:0];

      out_item_in.throttle_cmd = throttle_sum[10:0];
      out_item_in.yaw_cmd      = yaw_accum_in;
      out_item_in.roll_cmd     = angle_cmd(in_item_ff.roll_stick, in_item_ff.precision_mode);
      out_item_in.pitch_cmd    = angle_cmd(in_item_ff.pitch_stick, in_item_ff.precision_mode);
      out_item_in.motors_armed = in_item_ff.arm_request;
   end

   // Control registers and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pot_filter_ff <= 12'd0;
         primed_ff     <= 1'b0;
         yaw_accum_ff  <= 9'sd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (take) begin
            pot_filter_ff <= pot_filter_in;
            primed_ff     <= 1'b1;
            yaw_accum_ff  <= yaw_accum_in;
         end
      end
   end

   // Payload registers: load the input on acceptance, the result when it moves on
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (take) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_item_ff};

endmodule
